/* hdl/ksar_pkg.sv */
package ksar_pkg;

    // key table geometry
    localparam int KEY_COUNT = 256;
    localparam int KEY_AW    = (KEY_COUNT > 2) ? $clog2(KEY_COUNT) : 1;
    localparam int KEY_CW    = KEY_AW + 1;
    localparam int KEY_IW    = (KEY_AW > 8) ? KEY_AW : 8;

    // command kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_EVENT = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // flag bits
    localparam int FLAG_PRESSED  = 0;
    localparam int FLAG_HELD     = 1;
    localparam int FLAG_RELEASED = 2;
    localparam int FLAG_REPEATED = 3;

    // register indexes
    localparam logic [7:0] REG_INITIAL_DELAY = 8'd0;
    localparam logic [7:0] REG_REPEAT_PERIOD = 8'd1;

    localparam logic [7:0] INITIAL_DELAY_RST = 8'd30;
    localparam logic [7:0] REPEAT_PERIOD_RST = 8'd10;
    localparam logic [8:0] COUNT_MAX         = 9'h1FF;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] key_index;
        logic       pressed;
    } cmd_word_t;

    typedef struct packed {
        logic [3:0] key_flags;
        logic [7:0] repeat_timer;
        logic [8:0] repeats_this_tick;
    } rsp_word_t;

    typedef struct packed {
        logic [3:0] flags;
        logic [7:0] timer;
    } key_entry_t;

    typedef struct packed {
        logic              en;
        logic [KEY_AW-1:0] addr;
        key_entry_t        data;
    } mem_wr_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KEY,
        ST_TICK,
        ST_OUT
    } ksar_state_t;

endpackage

/* hdl/key_state_auto_repeat.sv */
// channel | dir | handshake            | word
// cmd     | in  | cmd_valid/cmd_stall  | cmd_word (kind, key_index, pressed)
// rsp     | out | rsp_valid/rsp_stall  | rsp_word (key_flags, repeat_timer, repeats_this_tick)
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A frame tick walks the key table memory one entry per cycle, read and write
// overlapped through the update unit, before its response is loaded.
// A key event or read passes an update and write state, then the response state;
// its memory read is issued at the accepting edge.
// After reset a clearing pass over every entry zeroes the table; no command is
// taken meanwhile, configuration writes are. A command is taken only in idle;
// a stalled response holds the sequencer until the response register frees.
module key_state_auto_repeat
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  ksar_pkg::cmd_word_t cmd_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ksar_pkg::rsp_word_t rsp_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    localparam int AW = ksar_pkg::KEY_AW;
    localparam int CW = ksar_pkg::KEY_CW;
    localparam int IW = ksar_pkg::KEY_IW;

    ksar_pkg::ksar_state_t state_reg, state_next;

    logic [7:0]           initial_delay_reg, initial_delay_next;
    logic [7:0]           repeat_period_reg, repeat_period_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        proc_idx_reg, proc_idx_next;
    logic                 proc_vld_reg, proc_vld_next;
    logic [1:0]           kind_reg, kind_next;
    logic                 press_reg, press_next;
    logic                 key_ok_reg, key_ok_next;
    logic [8:0]           count_reg, count_next;
    ksar_pkg::rsp_word_t  res_reg, res_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    ksar_pkg::rsp_word_t  rsp_word_reg, rsp_word_next;

    ksar_pkg::mem_wr_t    mem_wr;
    logic [AW-1:0]        rd_addr;
    ksar_pkg::key_entry_t rd_data;
    ksar_pkg::key_entry_t upd_entry;
    logic                 upd_repeated;
    logic                 upd_tick;
    logic                 upd_event;

    logic                 cmd_take;
    logic                 rsp_load;
    logic                 issue;
    logic                 walk_done;
    logic                 clear_done;
    logic                 cmd_key_ok;
    logic [IW-1:0]        cmd_key_ext;

    assign cmd_take    = cmd_valid && !cmd_stall;
    assign rsp_load    = (state_reg == ksar_pkg::ST_OUT) && (!rsp_valid_reg || !rsp_stall);
    assign issue       = idx_reg != CW'(ksar_pkg::KEY_COUNT);
    assign walk_done   = !issue && !proc_vld_reg;
    assign clear_done  = idx_reg == CW'(ksar_pkg::KEY_COUNT - 1);
    assign cmd_key_ok  = 32'(cmd_word.key_index) < ksar_pkg::KEY_COUNT;
    assign cmd_key_ext = IW'(cmd_word.key_index);

    assign cmd_stall = state_reg != ksar_pkg::ST_IDLE;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // key table and update unit
    ksar_mem u_mem
    (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ksar_unit u_unit
    (
        .entry         (rd_data),
        .tick_op       (upd_tick),
        .event_en      (upd_event),
        .pressed       (press_reg),
        .initial_delay (initial_delay_reg),
        .repeat_period (repeat_period_reg),
        .result        (upd_entry),
        .repeated      (upd_repeated)
    );

    assign upd_tick  = state_reg == ksar_pkg::ST_TICK;
    assign upd_event = kind_reg == ksar_pkg::KIND_EVENT;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ksar_pkg::ST_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = ksar_pkg::ST_IDLE;
                end
            end
            ksar_pkg::ST_IDLE:
            begin
                if (cmd_take)
                begin
                    unique case (cmd_word.kind) inside
                        ksar_pkg::KIND_TICK:  state_next = ksar_pkg::ST_TICK;
                        ksar_pkg::KIND_EVENT,
                        ksar_pkg::KIND_READ:  state_next = ksar_pkg::ST_KEY;
                        default:              state_next = ksar_pkg::ST_OUT;
                    endcase
                end
            end
            ksar_pkg::ST_KEY:
            begin
                state_next = ksar_pkg::ST_OUT;
            end
            ksar_pkg::ST_TICK:
            begin
                if (walk_done)
                begin
                    state_next = ksar_pkg::ST_OUT;
                end
            end
            ksar_pkg::ST_OUT:
            begin
                if (rsp_load)
                begin
                    state_next = ksar_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ksar_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs and datapath
    always_comb
    begin
        idx_next      = idx_reg;
        proc_idx_next = proc_idx_reg;
        proc_vld_next = 1'b0;
        kind_next     = kind_reg;
        press_next    = press_reg;
        key_ok_next   = key_ok_reg;
        count_next    = count_reg;
        res_next      = res_reg;
        rd_addr       = cmd_key_ext[AW-1:0];
        mem_wr.en     = 1'b0;
        mem_wr.addr   = proc_idx_reg;
        mem_wr.data   = upd_entry;
        unique case (state_reg)
            ksar_pkg::ST_CLEAR:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = idx_reg[AW-1:0];
                mem_wr.data = '0;
                idx_next    = clear_done ? '0 : idx_reg + CW'(1);
            end
            ksar_pkg::ST_IDLE:
            begin
                if (cmd_take)
                begin
                    kind_next     = cmd_word.kind;
                    press_next    = cmd_word.pressed;
                    key_ok_next   = cmd_key_ok;
                    proc_idx_next = cmd_key_ext[AW-1:0];
                    idx_next      = '0;
                    count_next    = '0;
                    res_next      = '0;
                end
            end
            ksar_pkg::ST_KEY:
            begin
                mem_wr.en = upd_event && key_ok_reg;
                if (key_ok_reg)
                begin
                    res_next.key_flags    = upd_entry.flags;
                    res_next.repeat_timer = upd_entry.timer;
                end
            end
            ksar_pkg::ST_TICK:
            begin
                // read one key ahead while the previous one is written back
                rd_addr       = idx_reg[AW-1:0];
                proc_vld_next = issue;
                if (issue)
                begin
                    idx_next      = idx_reg + CW'(1);
                    proc_idx_next = idx_reg[AW-1:0];
                end
                if (proc_vld_reg)
                begin
                    mem_wr.en = 1'b1;
                    if (upd_repeated && (count_reg != ksar_pkg::COUNT_MAX))
                    begin
                        count_next = count_reg + 9'd1;
                    end
                end
                if (walk_done)
                begin
                    res_next.repeats_this_tick = count_reg;
                end
            end
            ksar_pkg::ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // response register
    always_comb
    begin
        rsp_word_next  = rsp_word_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (rsp_load)
        begin
            rsp_word_next  = res_reg;
            rsp_valid_next = 1'b1;
        end
    end

    // configuration registers
    always_comb
    begin
        initial_delay_next = initial_delay_reg;
        repeat_period_next = repeat_period_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ksar_pkg::REG_INITIAL_DELAY: initial_delay_next = cfg_data;
                ksar_pkg::REG_REPEAT_PERIOD: repeat_period_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ksar_pkg::ST_CLEAR;
            idx_reg           <= '0;
            proc_vld_reg      <= 1'b0;
            count_reg         <= '0;
            rsp_valid_reg     <= 1'b0;
            initial_delay_reg <= ksar_pkg::INITIAL_DELAY_RST;
            repeat_period_reg <= ksar_pkg::REPEAT_PERIOD_RST;
        end
        else
        begin
            state_reg         <= state_next;
            idx_reg           <= idx_next;
            proc_vld_reg      <= proc_vld_next;
            count_reg         <= count_next;
            rsp_valid_reg     <= rsp_valid_next;
            initial_delay_reg <= initial_delay_next;
            repeat_period_reg <= repeat_period_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        proc_idx_reg <= proc_idx_next;
        kind_reg     <= kind_next;
        press_reg    <= press_next;
        key_ok_reg   <= key_ok_next;
        res_reg      <= res_next;
        rsp_word_reg <= rsp_word_next;
    end

`ifndef SYNTHESIS
    // tick walk hands over to the response stage once the last key is written
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ksar_pkg::ST_TICK) && walk_done |=> state_reg == ksar_pkg::ST_OUT)
        else $error("tick walk did not finish");

    // repeat count never exceeds keys issued so far
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ksar_pkg::ST_TICK |-> 32'(count_reg) <= 32'(idx_reg))
        else $error("repeat count ahead of walk");

    // a new response word only comes from the response stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == ksar_pkg::ST_OUT)
        else $error("response without response stage");

    // key table untouched while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ksar_pkg::ST_IDLE |-> !mem_wr.en)
        else $error("table write while idle");
`endif

endmodule

/* hdl/ksar_mem.sv */
module ksar_mem
(
    input  logic                           clk,
    input  ksar_pkg::mem_wr_t              wr,
    input  logic [ksar_pkg::KEY_AW-1:0]    rd_addr,
    output ksar_pkg::key_entry_t           rd_data
);

    ksar_pkg::key_entry_t mem_array [ksar_pkg::KEY_COUNT];
    ksar_pkg::key_entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_array[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_array[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/ksar_unit.sv */
module ksar_unit
(
    input  ksar_pkg::key_entry_t entry,
    input  logic                 tick_op,
    input  logic                 event_en,
    input  logic                 pressed,
    input  logic [7:0]           initial_delay,
    input  logic [7:0]           repeat_period,
    output ksar_pkg::key_entry_t result,
    output logic                 repeated
);

    logic [3:0] flags_base;
    logic [7:0] timer_inc;

    assign flags_base = entry.flags & ~(4'd1 << ksar_pkg::FLAG_REPEATED);
    assign timer_inc  = entry.timer + 8'd1;

    // per-key update, shared by frame ticks and key events
    always_comb
    begin
        result   = entry;
        repeated = 1'b0;
        if (tick_op)
        begin
            result.flags = flags_base;
            if (flags_base[ksar_pkg::FLAG_RELEASED])
            begin
                result.flags = 4'd0;
                result.timer = 8'd0;
            end
            else if (flags_base[ksar_pkg::FLAG_PRESSED])
            begin
                result.flags = 4'd1 << ksar_pkg::FLAG_HELD;
                result.timer = 8'd1;
            end
            else if (flags_base[ksar_pkg::FLAG_HELD])
            begin
                result.timer = timer_inc;
                if (timer_inc > initial_delay)
                begin
                    result.flags = flags_base | (4'd1 << ksar_pkg::FLAG_REPEATED);
                    result.timer = initial_delay - repeat_period;
                    repeated     = 1'b1;
                end
            end
        end
        else if (event_en)
        begin
            if (pressed)
            begin
                result.flags = entry.flags | (4'd1 << ksar_pkg::FLAG_PRESSED);
            end
            else
            begin
                result.flags = entry.flags | (4'd1 << ksar_pkg::FLAG_RELEASED);
            end
        end
    end

endmodule

/* tb/testbench.sv */
module testbench;
    import ksar_pkg::*;

    // the package names no code for the spare kind
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // cycles with no word moving on any channel before the run is abandoned
    localparam int IDLE_LIMIT = 8000;

    // expected key table and the queue of response words still owed
    class key_repeat_scoreboard;
        logic [3:0] flag_table [KEY_COUNT];
        logic [7:0] timer_table [KEY_COUNT];
        logic [7:0] initial_delay;
        logic [7:0] repeat_period;
        rsp_word_t  expected_words [$];
        int errors;
        int ticks;
        int events;
        int reads;
        int unused;
        int repeats_total;
        int repeats_peak;

        function new();
            foreach (flag_table[k])
            begin
                flag_table[k]  = '0;
                timer_table[k] = '0;
            end
            initial_delay = INITIAL_DELAY_RST;
            repeat_period = REPEAT_PERIOD_RST;
        endfunction

        function void set_register(logic [7:0] index, logic [7:0] value);
            if (index == REG_INITIAL_DELAY)
                initial_delay = value;
            else if (index == REG_REPEAT_PERIOD)
                repeat_period = value;
        endfunction

        // one frame: walk all keys in order, return how many started repeating
        function logic [8:0] frame_tick();
            int count;
            logic [3:0] f;
            logic [7:0] t;
            count = 0;
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                f = flag_table[k];
                f[FLAG_REPEATED] = 1'b0;
                if (f[FLAG_RELEASED])
                begin
                    f = '0;
                    timer_table[k] = 8'd0;
                end
                else if (f[FLAG_PRESSED])
                begin
                    f = '0;
                    f[FLAG_HELD] = 1'b1;
                    timer_table[k] = 8'd1;
                end
                else if (f[FLAG_HELD])
                begin
                    t = timer_table[k] + 8'd1;
                    if (t > initial_delay)
                    begin
                        f[FLAG_REPEATED] = 1'b1;
                        // reload wraps when the period exceeds the delay
                        t = initial_delay - repeat_period;
                        if (count < int'(COUNT_MAX))
                            count++;
                    end
                    timer_table[k] = t;
                end
                flag_table[k] = f;
            end
            return 9'(count);
        endfunction

        // accepted command word: update the table and queue its response
        function void note_command(cmd_word_t c);
            rsp_word_t want;
            want = '0;
            case (c.kind)
                KIND_TICK:
                begin
                    ticks++;
                    want.repeats_this_tick = frame_tick();
                    repeats_total += int'(want.repeats_this_tick);
                    if (int'(want.repeats_this_tick) > repeats_peak)
                        repeats_peak = int'(want.repeats_this_tick);
                end
                KIND_EVENT, KIND_READ:
                begin
                    if (c.kind == KIND_EVENT)
                        events++;
                    else
                        reads++;
                    if (int'(c.key_index) < KEY_COUNT)
                    begin
                        if (c.kind == KIND_EVENT)
                        begin
                            if (c.pressed)
                                flag_table[c.key_index][FLAG_PRESSED] = 1'b1;
                            else
                                flag_table[c.key_index][FLAG_RELEASED] = 1'b1;
                        end
                        want.key_flags    = flag_table[c.key_index];
                        want.repeat_timer = timer_table[c.key_index];
                    end
                end
                default:
                    unused++;
            endcase
            expected_words.push_back(want);
        endfunction

        // accepted response word against the oldest expectation
        function void check_response(rsp_word_t got);
            rsp_word_t want;
            if (expected_words.size() == 0)
            begin
                $error("response word with no command outstanding: %0h", got);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got.key_flags !== want.key_flags)
            begin
                $error("key_flags: expected %0h, got %0h", want.key_flags, got.key_flags);
                errors++;
            end
            if (got.repeat_timer !== want.repeat_timer)
            begin
                $error("repeat_timer: expected %0d, got %0d",
                       want.repeat_timer, got.repeat_timer);
                errors++;
            end
            if (got.repeats_this_tick !== want.repeats_this_tick)
            begin
                $error("repeats_this_tick: expected %0d, got %0d",
                       want.repeats_this_tick, got.repeats_this_tick);
                errors++;
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    cmd_word_t  cmd_word  = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    rsp_word_t  rsp_word;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    key_repeat_scoreboard board;
    logic [7:0] key_pool [8];
    int burst_left  = 0;
    int settings    = 0;
    int idle_cycles = 0;
    int stall_mode  = 0;
    int stall_span  = 0;

    key_state_auto_repeat dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // receiver stall pattern: spans of no stall, light stall and heavy stall
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_span = $urandom_range(20, 200);
        end
        else
            stall_span--;
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // monitor: responses checked before the command of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                board.check_response(rsp_word);
            if (cmd_valid && !cmd_stall)
                board.note_command(cmd_word);
            if ((rsp_valid && !rsp_stall) || (cmd_valid && !cmd_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic cmd_word_t cmd_of(logic [1:0] kind, logic [7:0] key, logic pressed);
        cmd_word_t w;
        w.kind      = kind;
        w.key_index = key;
        w.pressed   = pressed;
        return w;
    endfunction

    // send one command word, with bursts and gaps between them
    task automatic issue_command(input cmd_word_t w);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
            begin
                @(negedge clk);
                cmd_valid <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        do @(posedge clk); while (cmd_stall);
    endtask

    // hold the sender until every owed response has come back
    task automatic wait_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (board.expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [7:0] index, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        board.set_register(index, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one register setting, then frames of events, reads and spare-kind words closed by a tick
    task automatic run_phase(input logic [7:0] delay, input logic [7:0] period,
                             input int items, input int max_between, input int release_pct);
        int sent;
        int between;
        int r;
        logic [1:0] kind;
        cmd_word_t w;
        wait_drained();
        write_register(REG_INITIAL_DELAY, delay);
        write_register(REG_REPEAT_PERIOD, period);
        settings++;
        for (int i = 0; i < 8; i++)
            key_pool[i] = 8'($urandom_range(0, 255));
        sent = 0;
        while (sent < items)
        begin
            between = $urandom_range(0, max_between);
            repeat (between)
            begin
                r = $urandom_range(0, 19);
                kind = (r < 10) ? KIND_EVENT : ((r < 18) ? KIND_READ : KIND_UNUSED);
                w.kind = kind;
                w.key_index = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                          : key_pool[$urandom_range(0, 7)];
                if (kind == KIND_EVENT)
                    w.pressed = ($urandom_range(1, 100) > release_pct);
                else
                    w.pressed = 1'($urandom);
                issue_command(w);
                sent++;
            end
            issue_command(cmd_of(KIND_TICK, 8'($urandom), 1'($urandom)));
            sent++;
        end
    endtask

    initial
    begin
        board = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, extreme keys, spare kind, press and release in one frame
        issue_command(cmd_of(KIND_READ, 8'd0, 1'b0));
        issue_command(cmd_of(KIND_READ, 8'd255, 1'b1));
        issue_command(cmd_of(KIND_UNUSED, 8'd255, 1'b1));
        issue_command(cmd_of(KIND_EVENT, 8'd0, 1'b1));
        issue_command(cmd_of(KIND_EVENT, 8'd255, 1'b0));
        issue_command(cmd_of(KIND_EVENT, 8'd85, 1'b1));
        issue_command(cmd_of(KIND_EVENT, 8'd85, 1'b0));
        issue_command(cmd_of(KIND_EVENT, 8'd170, 1'b1));
        issue_command(cmd_of(KIND_READ, 8'd85, 1'b0));
        issue_command(cmd_of(KIND_TICK, 8'd255, 1'b1));
        issue_command(cmd_of(KIND_READ, 8'd0, 1'b0));
        issue_command(cmd_of(KIND_READ, 8'd85, 1'b0));
        issue_command(cmd_of(KIND_READ, 8'd255, 1'b0));
        issue_command(cmd_of(KIND_TICK, 8'd0, 1'b0));
        issue_command(cmd_of(KIND_TICK, 8'd0, 1'b0));
        // press again while held
        issue_command(cmd_of(KIND_EVENT, 8'd0, 1'b1));
        issue_command(cmd_of(KIND_READ, 8'd0, 1'b0));
        issue_command(cmd_of(KIND_TICK, 8'd0, 1'b0));
        issue_command(cmd_of(KIND_READ, 8'd0, 1'b0));

        // shortest delays: held keys repeat right away
        wait_drained();
        write_register(REG_INITIAL_DELAY, 8'd1);
        write_register(REG_REPEAT_PERIOD, 8'd1);
        settings++;
        issue_command(cmd_of(KIND_TICK, 8'd0, 1'b0));
        issue_command(cmd_of(KIND_READ, 8'd170, 1'b0));
        issue_command(cmd_of(KIND_TICK, 8'd0, 1'b0));
        issue_command(cmd_of(KIND_READ, 8'd170, 1'b0));
        issue_command(cmd_of(KIND_TICK, 8'd0, 1'b0));

        // random phases across register settings, extremes and a wrapping reload
        run_phase(8'd1, 8'd1, 150, 4, 40);
        run_phase(8'd254, 8'd1, 380, 1, 5);
        run_phase(8'd254, 8'd254, 120, 3, 30);
        run_phase(8'd5, 8'd200, 150, 3, 40);
        run_phase(8'd2, 8'd1, 200, 5, 50);
        run_phase(8'd30, 8'd10, 150, 3, 20);
        run_phase(8'd8, 8'd3, 150, 4, 40);

        // drain, then watch for stray responses for about one tick
        wait_drained();
        repeat (KEY_COUNT + 8) @(posedge clk);

        $display("run covered %0d ticks, %0d key events, %0d reads, %0d spare-kind words",
                 board.ticks, board.events, board.reads, board.unused);
        $display("%0d register settings, %0d repeats seen, at most %0d in one tick",
                 settings, board.repeats_total, board.repeats_peak);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
hdl/ksar_pkg.sv
hdl/ksar_mem.sv
hdl/ksar_unit.sv
hdl/key_state_auto_repeat.sv
tb/testbench.sv
